// ===== src/assert_macros.svh =====
// Assertion helpers for the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/u2u8_pkg.sv =====
package u2u8_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int CAP_W          = 24;
   localparam int BC_W           = 24;
   localparam int UNIT_W         = 16;
   localparam int CP_W           = 21;
   localparam int MAX_RESULTS    = 7;
   localparam int IDX_W          = 3;
   localparam int LIST_DEPTH     = 2 ** IDX_W;

   localparam logic [CAP_W-1:0]  CAP_RESET   = 24'hFF_FFFF;

   localparam logic [UNIT_W-1:0] SURR_HI_MIN = 16'hD800;
   localparam logic [UNIT_W-1:0] SURR_HI_MAX = 16'hDBFF;
   localparam logic [UNIT_W-1:0] SURR_LO_MIN = 16'hDC00;
   localparam logic [UNIT_W-1:0] SURR_LO_MAX = 16'hDFFF;

   localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h01_0000;
   localparam logic [CP_W-1:0]   CP_1B_LIMIT  = 21'h00_0080;
   localparam logic [CP_W-1:0]   CP_2B_LIMIT  = 21'h00_0800;
   localparam logic [CP_W-1:0]   CP_3B_LIMIT  = 21'h01_0000;

   localparam logic [7:0] CONT_MARK = 8'h80;
   localparam logic [7:0] LEAD_2B   = 8'hC0;
   localparam logic [7:0] LEAD_3B   = 8'hE0;
   localparam logic [7:0] LEAD_4B   = 8'hF0;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;
   } cp_enc_type;

   typedef struct packed {
      logic [UNIT_W-1:0] held_high;
      logic              holding;
      logic              stopped;
   } hold_state_type;

   function automatic cp_enc_type utf8_encode(input logic [CP_W-1:0] cp);
      cp_enc_type r;
      r.len   = 3'd0;
      r.bytes = '0;
      if (cp < CP_1B_LIMIT) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < CP_2B_LIMIT) begin
         r.len      = 3'd2;
         r.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      end else if (cp < CP_3B_LIMIT) begin
         r.len      = 3'd3;
         r.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         r.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
         r.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
         r.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
      end
      return r;
   endfunction

endpackage

// ===== src/utf16_to_utf8_encoder_top.sv =====
// Channel   Dir  Ports                 Contents (low bit up)
// req       in   req_tdata/tlast       code_unit[15:0]; tlast = last_unit
// rsp       out  rsp_tdata/tlast/tuser out_byte[7:0], byte_count[31:8];
//                                      tlast = run_end; tuser = is_terminator
// csr       in   csr_wr_en/wr_data     out_capacity[23:0]
//
// An item gives one result per cycle while rsp is not stalled (0 to 7
// results); a held high surrogate with no results retires without using the
// rsp output. The byte-wide rsp output register sets this rate.
// Reset is synchronous, active high, clears string state and sets capacity
// to its maximum.
// A stalled rsp holds its register; the next item is taken in the cycle the
// last result of the current one is loaded.
`include "assert_macros.svh"

module utf16_to_utf8_encoder_top #(
   parameter int COUNT_BITS = u2u8_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // req: code_unit[15:0]
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp: out_byte[7:0], byte_count[31:8]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: is_terminator
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   localparam int IW   = u2u8_pkg::IDX_W;
   localparam int BC_W = u2u8_pkg::BC_W;

   // Capacity register.
   logic [u2u8_pkg::CAP_W-1:0] cap_ff;

   // Input item register.
   logic                        item_vld_ff, item_vld_in;
   logic [u2u8_pkg::UNIT_W-1:0] unit_ff;
   logic                        last_ff;

   // String state.
   u2u8_pkg::hold_state_type    st_ff, st_in;
   logic [COUNT_BITS-1:0]       written_ff, written_in;

   // Position within the current item's results.
   logic [IW-1:0]               idx_ff, idx_in;

   // Output register.
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_end_ff, rsp_end_in;
   logic                        rsp_term_ff, rsp_term_in;
   logic [BC_W-1:0]             rsp_cnt_ff, rsp_cnt_in;

   logic [u2u8_pkg::LIST_DEPTH-1:0][7:0] byte_list;
   logic [IW-1:0]               n_bytes, total;
   u2u8_pkg::hold_state_type    st_next;
   logic [COUNT_BITS-1:0]       written_next;
   logic                        slot_free, load, done, is_term, is_end;
   logic [COUNT_BITS-1:0]       cnt_full;

   u2u8_encode #(
      .COUNT_BITS(COUNT_BITS)
   ) u_encode (
      .unit_i      (unit_ff),
      .last_i      (last_ff),
      .st_i        (st_ff),
      .written_i   (written_ff),
      .cap_i       (cap_ff),
      .byte_list_o (byte_list),
      .n_bytes_o   (n_bytes),
      .total_o     (total),
      .st_o        (st_next),
      .written_o   (written_next)
   );

   // The output slot frees up when empty or when its item is taken now.
   assign slot_free = ~rsp_vld_ff | rsp_tready;
   assign load      = item_vld_ff & (total != '0) & slot_free;
   assign is_end    = (idx_ff == total - 1'b1);
   assign is_term   = last_ff & (idx_ff == n_bytes);
   // Retire the item once its last result is loaded, or at once if it has none.
   assign done      = item_vld_ff & ((total == '0) | (load & is_end));

   assign req_tready = ~item_vld_ff | done;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_tvalid & req_tready) begin
         item_vld_in = 1'b1;
      end else if (done) begin
         item_vld_in = 1'b0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (done) begin
         idx_in = '0;
      end else if (load) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Bytes count up from the string's running total; the terminator sits right
   // after the item's bytes, so its position gives the final length.
   assign cnt_full = is_term ? written_ff + COUNT_BITS'(idx_ff) :
                     written_ff + COUNT_BITS'(idx_ff) + 1'b1;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_term_in = rsp_term_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      if (load) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = is_term ? 8'h00 : byte_list[idx_ff];
         rsp_end_in  = is_end;
         rsp_term_in = is_term;
         rsp_cnt_in  = BC_W'(cnt_full);
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign st_in      = done ? st_next : st_ff;
   assign written_in = done ? written_next : written_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= u2u8_pkg::CAP_RESET;
         item_vld_ff <= 1'b0;
         st_ff       <= '0;
         written_ff  <= '0;
         idx_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         item_vld_ff <= item_vld_in;
         st_ff       <= st_in;
         written_ff  <= written_in;
         idx_ff      <= idx_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_tvalid & req_tready) begin
         unit_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_term_ff <= rsp_term_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tuser  = rsp_term_ff;

   // The result position never runs past the item's result count.
   `ASSERT_SAME(a_idx_bound, clock, reset, item_vld_ff & (total != '0), idx_ff < total)
   // An item that is not retired stays in the input register.
   `ASSERT_NEXT(a_item_holds, clock, reset, item_vld_ff & ~done, item_vld_ff)
   // A terminator is always the last result of its item.
   `ASSERT_SAME(a_term_end, clock, reset, rsp_vld_ff & rsp_term_ff, rsp_end_ff)
   // Retiring the final unit of a string clears the string state.
   `ASSERT_NEXT(a_str_clear, clock, reset, done & last_ff,
                (written_ff == '0) & ~st_ff.holding & ~st_ff.stopped)

endmodule

// ===== src/u2u8_encode.sv =====
// Work out all results of one code unit and the state it leaves behind.
module u2u8_encode #(
   parameter int COUNT_BITS = u2u8_pkg::COUNT_BITS_DEF
) (
   input  logic [u2u8_pkg::UNIT_W-1:0]        unit_i,
   input  logic                               last_i,
   input  u2u8_pkg::hold_state_type           st_i,
   input  logic [COUNT_BITS-1:0]              written_i,
   input  logic [u2u8_pkg::CAP_W-1:0]         cap_i,
   output logic [u2u8_pkg::LIST_DEPTH-1:0][7:0] byte_list_o,
   output logic [u2u8_pkg::IDX_W-1:0]         n_bytes_o,
   output logic [u2u8_pkg::IDX_W-1:0]         total_o,
   output u2u8_pkg::hold_state_type           st_o,
   output logic [COUNT_BITS-1:0]              written_o
);

   localparam int CW = (COUNT_BITS + 1 > u2u8_pkg::CAP_W + 1) ?
                       COUNT_BITS + 1 : u2u8_pkg::CAP_W + 1;
   localparam int IW = u2u8_pkg::IDX_W;

   logic                        is_high, is_low, pair, hold_new;
   logic                        pres_a, pres_b;
   logic [u2u8_pkg::CP_W-1:0]   cp_a, cp_b;
   u2u8_pkg::cp_enc_type        enc_a, enc_b;
   logic [COUNT_BITS:0]         after_a, after_b;
   logic                        fit_a, fit_b;
   logic                        take_a, take_b;
   logic                        stop_a, stop_b;
   logic [COUNT_BITS-1:0]       w_a, w_b;
   logic [IW-1:0]               n_a, n_b;
   logic [IW-1:0]               kb;

   assign is_high  = unit_i inside {[u2u8_pkg::SURR_HI_MIN:u2u8_pkg::SURR_HI_MAX]};
   assign is_low   = unit_i inside {[u2u8_pkg::SURR_LO_MIN:u2u8_pkg::SURR_LO_MAX]};
   assign pair     = st_i.holding & is_low;
   assign hold_new = is_high & ~last_i;

   // Up to two code points: a held or paired one first, then the new unit.
   always_comb begin
      if (pair) begin
         cp_a   = {1'b0, st_i.held_high[9:0], unit_i[9:0]} + u2u8_pkg::CP_SUPP_BASE;
         pres_a = 1'b1;
         cp_b   = '0;
         pres_b = 1'b0;
      end else if (st_i.holding) begin
         cp_a   = {5'b00000, st_i.held_high};
         pres_a = 1'b1;
         cp_b   = {5'b00000, unit_i};
         pres_b = ~hold_new;
      end else begin
         cp_a   = {5'b00000, unit_i};
         pres_a = ~hold_new;
         cp_b   = '0;
         pres_b = 1'b0;
      end
   end

   assign enc_a = u2u8_pkg::utf8_encode(cp_a);
   assign enc_b = u2u8_pkg::utf8_encode(cp_b);

   // A code point fits if its bytes plus the terminator stay inside capacity.
   assign after_a = {1'b0, written_i} + (COUNT_BITS + 1)'(enc_a.len);
   assign fit_a   = (CW'(after_a) < CW'(cap_i)) & ~after_a[COUNT_BITS];
   assign take_a  = pres_a & ~st_i.stopped & fit_a;
   assign stop_a  = st_i.stopped | (pres_a & ~fit_a);
   assign w_a     = take_a ? after_a[COUNT_BITS-1:0] : written_i;
   assign n_a     = take_a ? enc_a.len : '0;

   assign after_b = {1'b0, w_a} + (COUNT_BITS + 1)'(enc_b.len);
   assign fit_b   = (CW'(after_b) < CW'(cap_i)) & ~after_b[COUNT_BITS];
   assign take_b  = pres_b & ~stop_a & fit_b;
   assign stop_b  = stop_a | (pres_b & ~fit_b);
   assign w_b     = take_b ? after_b[COUNT_BITS-1:0] : w_a;
   assign n_b     = take_b ? enc_b.len : '0;

   assign n_bytes_o = n_a + n_b;
   assign total_o   = n_a + n_b + IW'(last_i);

   // Lay the bytes of both code points end to end; the terminator slot reads zero.
   always_comb begin
      for (int k = 0; k < u2u8_pkg::LIST_DEPTH; k++) begin
         kb = IW'(k) - n_a;
         if (IW'(k) < n_a) begin
            byte_list_o[k] = enc_a.bytes[k[1:0]];
         end else if (IW'(k) < n_bytes_o) begin
            byte_list_o[k] = enc_b.bytes[kb[1:0]];
         end else begin
            byte_list_o[k] = '0;
         end
      end
   end

   // Drop all string state after the last unit.
   always_comb begin
      if (last_i) begin
         st_o      = '0;
         written_o = '0;
      end else begin
         st_o.held_high = hold_new ? unit_i : '0;
         st_o.holding   = hold_new;
         st_o.stopped   = stop_b;
         written_o      = w_b;
      end
   end

endmodule

// ===== verif/utf16_to_utf8_checker.sv =====
module utf16_to_utf8_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       req_tdata,
   input  logic              req_tlast,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [31:0]       rsp_tdata,
   input  logic              rsp_tlast,
   input  logic              rsp_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_wr_en,
   input  logic [23:0]       csr_wr_data,
   output int unsigned       error_count,
   output int unsigned       pending_count
);

   localparam int UNIT_W = u2u8_pkg::UNIT_W;
   localparam int CP_W   = u2u8_pkg::CP_W;
   localparam int BC_W   = u2u8_pkg::BC_W;
   localparam int CAP_W  = u2u8_pkg::CAP_W;
   localparam longint unsigned COUNT_MAX = (64'd1 << u2u8_pkg::COUNT_BITS_DEF) - 1;

   typedef struct packed {
      logic [7:0]      out_byte;
      logic            run_end;
      logic            is_term;
      logic [BC_W-1:0] byte_count;
   } utf8_result_type;

   utf8_result_type   expected_bytes[$];

   logic [UNIT_W-1:0] held_surrogate;
   logic              have_surrogate;
   logic [BC_W-1:0]   bytes_written;
   logic              overflowed;
   logic [CAP_W-1:0]  capacity;

   // Queue the bytes of one code point, or latch the overflow if it does not fit.
   function automatic void encode_point(input logic [CP_W-1:0] cp);
      logic [3:0][7:0] seq;
      int unsigned     len;
      longint unsigned after;
      utf8_result_type r;
      seq = '0;
      if (overflowed) return;
      if (cp < 21'h80) begin
         len    = 1;
         seq[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         len    = 2;
         seq[0] = u2u8_pkg::LEAD_2B | 8'(cp >> 6);
         seq[1] = u2u8_pkg::CONT_MARK | 8'(cp & 21'h3F);
      end else if (cp < 21'h10000) begin
         len    = 3;
         seq[0] = u2u8_pkg::LEAD_3B | 8'(cp >> 12);
         seq[1] = u2u8_pkg::CONT_MARK | 8'((cp >> 6) & 21'h3F);
         seq[2] = u2u8_pkg::CONT_MARK | 8'(cp & 21'h3F);
      end else begin
         len    = 4;
         seq[0] = u2u8_pkg::LEAD_4B | 8'((cp >> 18) & 21'h07);
         seq[1] = u2u8_pkg::CONT_MARK | 8'((cp >> 12) & 21'h3F);
         seq[2] = u2u8_pkg::CONT_MARK | 8'((cp >> 6) & 21'h3F);
         seq[3] = u2u8_pkg::CONT_MARK | 8'(cp & 21'h3F);
      end
      after = longint'(bytes_written) + len;
      if (after >= longint'(capacity) || after > COUNT_MAX) begin
         overflowed = 1'b1;
         return;
      end
      for (int i = 0; i < len; i++) begin
         bytes_written = bytes_written + 1'b1;
         r.out_byte    = seq[i];
         r.run_end     = 1'b0;
         r.is_term     = 1'b0;
         r.byte_count  = bytes_written;
         expected_bytes.push_back(r);
      end
   endfunction

   function automatic void predict_unit(input logic [UNIT_W-1:0] unit, input logic last);
      logic            is_high;
      logic            is_low;
      logic [CP_W-1:0] cp;
      int unsigned     base;
      utf8_result_type r;
      base    = expected_bytes.size();
      is_high = (unit >= u2u8_pkg::SURR_HI_MIN) && (unit <= u2u8_pkg::SURR_HI_MAX);
      is_low  = (unit >= u2u8_pkg::SURR_LO_MIN) && (unit <= u2u8_pkg::SURR_LO_MAX);
      if (have_surrogate && is_low) begin
         cp = ((CP_W'(held_surrogate) - CP_W'(u2u8_pkg::SURR_HI_MIN)) << 10)
              + (CP_W'(unit) - CP_W'(u2u8_pkg::SURR_LO_MIN)) + u2u8_pkg::CP_SUPP_BASE;
         have_surrogate = 1'b0;
         held_surrogate = '0;
         encode_point(cp);
      end else begin
         if (have_surrogate) begin
            have_surrogate = 1'b0;
            encode_point(CP_W'(held_surrogate));
            held_surrogate = '0;
         end
         if (is_high && !last) begin
            have_surrogate = 1'b1;
            held_surrogate = unit;
         end else begin
            encode_point(CP_W'(unit));
         end
      end
      if (last) begin
         r.out_byte   = 8'h00;
         r.run_end    = 1'b0;
         r.is_term    = 1'b1;
         r.byte_count = bytes_written;
         expected_bytes.push_back(r);
         held_surrogate = '0;
         have_surrogate = 1'b0;
         bytes_written  = '0;
         overflowed     = 1'b0;
      end
      // Flag the final result of this item.
      if (expected_bytes.size() > base) begin
         r         = expected_bytes.pop_back();
         r.run_end = 1'b1;
         expected_bytes.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      utf8_result_type got;
      utf8_result_type want;
      if (reset) begin
         expected_bytes.delete();
         held_surrogate = '0;
         have_surrogate = 1'b0;
         bytes_written  = '0;
         overflowed     = 1'b0;
         capacity       = u2u8_pkg::CAP_RESET;
         error_count    = 0;
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte   = rsp_tdata[7:0];
            got.run_end    = rsp_tlast;
            got.is_term    = rsp_tuser;
            got.byte_count = rsp_tdata[31:8];
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected rsp item: expected none,", $time,
                        " actual byte=%02h end=%0b term=%0b count=%0d",
                        got.out_byte, got.run_end, got.is_term, got.byte_count);
            end else begin
               want = expected_bytes.pop_front();
               if (got.out_byte !== want.out_byte || got.run_end !== want.run_end ||
                   got.is_term !== want.is_term || got.byte_count !== want.byte_count) begin
                  error_count++;
                  $display("%0t: rsp mismatch: expected byte=%02h end=%0b term=%0b count=%0d,",
                           $time, want.out_byte, want.run_end, want.is_term,
                           want.byte_count,
                           " actual byte=%02h end=%0b term=%0b count=%0d",
                           got.out_byte, got.run_end, got.is_term, got.byte_count);
               end
            end
         end
         if (req_tvalid && req_tready) predict_unit(req_tdata, req_tlast);
      end
      pending_count = expected_bytes.size();
   end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

   // This module only makes stimulus and gives the verdict; the checker beside
   // the block predicts every rsp item from the req items and capacity writes
   // it sees, and compares the results field by field.

   // Total req items to send; directed strings come first.
   localparam int unsigned TARGET_ITEMS = 300;
   // Cycles to let pass after the last expected result before a write or the verdict.
   localparam int unsigned SETTLE_CYCLES = 16;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_SPARSE
   } stall_mode_type;

   // All block inputs start at known values.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic [15:0] req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [23:0] csr_wr_data = '0;

   int unsigned error_count;
   int unsigned pending_count;

   int unsigned sent_items  = 0;
   int unsigned burst_left  = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int unsigned mode_cycles = 0;
   int unsigned stall_phase = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   utf16_to_utf8_encoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   utf16_to_utf8_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Receiver back-pressure: switch between stall patterns at random, so that
   // stalls land on every byte of a code point and on the terminator, with
   // stretches of no stall at all.
   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode  <= stall_mode_type'($urandom_range(0, 3));
         mode_cycles <= $urandom_range(20, 200);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         STALL_NONE:     rsp_tready <= 1'b1;
         STALL_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_tready <= (stall_phase % 4 == 0);
         default:        rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Present one code unit and hold it until the block takes it. The sender
   // runs in bursts; between bursts drop valid for a random gap, sometimes none.
   // Called and returns at a falling edge.
   task automatic send_unit(input logic [15:0] unit, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_tdata  <= unit;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent_items++;
   endtask

   // Drain the block, give it time to finish any item with no result, then
   // write the capacity register.
   task automatic write_capacity(input logic [23:0] cap);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Build a random string, mostly well-formed UTF-16 with random content,
   // plus lone surrogates and raw noise, then send it with tlast on the end.
   task automatic send_random_string();
      logic [15:0] units[$];
      int unsigned len;
      len = $urandom_range(1, 10);
      while (units.size() < len) begin
         case ($urandom_range(0, 9))
            0, 1: units.push_back(16'($urandom_range(16'h0000, 16'h007F)));
            2:    units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
            3:    units.push_back(16'($urandom_range(16'h0800, 16'hFFFF)));
            4:    units.push_back(16'($urandom));
            5:    units.push_back(u2u8_pkg::SURR_LO_MIN | 16'($urandom_range(0, 1023)));
            6:    units.push_back(u2u8_pkg::SURR_HI_MIN | 16'($urandom_range(0, 1023)));
            default: begin
               units.push_back(u2u8_pkg::SURR_HI_MIN | 16'($urandom_range(0, 1023)));
               units.push_back(u2u8_pkg::SURR_LO_MIN | 16'($urandom_range(0, 1023)));
            end
         endcase
      end
      for (int i = 0; i < units.size(); i++) begin
         send_unit(units[i], i == units.size() - 1);
      end
   endtask

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("tb_top failed");
      $finish;
   end

   initial begin
      logic [23:0] cap;
      int unsigned strings;

      // Hold reset, then release it at a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Boundaries of each encoded length at the reset capacity.
      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hFFFF, 1'b1);

      // Surrogate pairs at the edges of both ranges.
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b1);

      // Lone low, held high followed by a plain unit, high followed by high,
      // and a high surrogate as the last unit.
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hD800, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDFFF, 1'b0);
      send_unit(16'hDBFF, 1'b1);

      // Capacity of one: only the terminator fits.
      write_capacity(24'd1);
      send_unit(16'h0041, 1'b1);

      // Zero capacity: nothing fits, terminator still comes out.
      write_capacity(24'd0);
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b1);

      // Pair overflows; the following unit would fit but the string is stopped.
      write_capacity(24'd4);
      send_unit(16'hD83D, 1'b0);
      send_unit(16'hDE00, 1'b0);
      send_unit(16'h0041, 1'b1);

      // Random phases: new capacity, then a few strings.
      while (sent_items < TARGET_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       cap = u2u8_pkg::CAP_RESET;
            1:       cap = 24'($urandom);
            2:       cap = 24'($urandom_range(0, 2));
            default: cap = 24'($urandom_range(3, 30));
         endcase
         write_capacity(cap);
         strings = $urandom_range(2, 5);
         repeat (strings) send_random_string();
      end

      // Drain, then allow the block's latency before the verdict.
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
